>>> rtl/crrb_pkg.sv
// shared types and constants for the contiguous-reserve ring pointer engine
// no dependencies; used by every module under rtl
package crrb_pkg;

   // ring size in bytes (4096); the offset and count fields take their 12-bit width from it
   localparam int RING_BYTES = 4096;
   localparam int OFS_W      = $clog2(RING_BYTES);
   localparam int SPAN_W     = OFS_W + 1;

   // request codes
   typedef enum logic [1:0] {
      ACT_RESERVE = 2'd0,
      ACT_COMMIT  = 2'd1,
      ACT_PEEK    = 2'd2,
      ACT_CONSUME = 2'd3
   } action_type;

   // one request transaction
   typedef struct packed {
      action_type        action;
      logic [OFS_W-1:0]  byte_count;
   } req_type;

   // one response transaction
   typedef struct packed {
      logic              granted;
      logic [OFS_W-1:0]  offset;
      logic [OFS_W-1:0]  bytes_available;
   } rsp_type;

endpackage

>>> rtl/crrb_core.sv
// offset registers and the combinational reserve/commit/peek/consume logic
// depends on crrb_pkg
module crrb_core
   import crrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   output rsp_type rsp
);

   logic [OFS_W-1:0]  wr_ff, wr_in;
   logic [OFS_W-1:0]  rd_ff, rd_in;
   logic [OFS_W-1:0]  end_ff, end_in;
   logic [SPAN_W-1:0] tail;
   logic [SPAN_W-1:0] free_bytes;
   logic [SPAN_W-1:0] count_ext;

   assign count_ext = {1'b0, req.byte_count};
   assign tail      = SPAN_W'(RING_BYTES) - {1'b0, wr_ff};

   // next offsets and the response for the transaction in the input register
   always_comb begin
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      end_in     = end_ff;
      free_bytes = '0;
      rsp        = '{granted: 1'b1, offset: '0, bytes_available: '0};
      case (req.action)
         ACT_RESERVE: begin
            // tail free space, or wrap to the front when the tail is too short
            if (rd_ff <= wr_ff) begin
               free_bytes = tail;
               if (tail <= count_ext) begin
                  end_in = wr_ff;
                  if (rd_ff != '0) begin
                     wr_in      = '0;
                     free_bytes = {1'b0, rd_ff};
                  end
               end
            end else begin
               free_bytes = {1'b0, rd_ff} - {1'b0, wr_ff};
            end
            if (free_bytes > count_ext) begin
               rsp.offset = wr_in;
            end else begin
               rsp.granted = 1'b0;
            end
         end
         ACT_COMMIT: begin
            wr_in = wr_ff + req.byte_count;
         end
         ACT_PEEK: begin
            // readable span up to the end mark, else roll the reader to 0
            if (wr_ff < rd_ff) begin
               if (end_ff > rd_ff) begin
                  rsp.bytes_available = end_ff - rd_ff;
                  rsp.offset          = rd_ff;
               end else begin
                  rd_in               = '0;
                  rsp.bytes_available = wr_ff;
                  rsp.offset          = '0;
               end
            end else begin
               rsp.bytes_available = wr_ff - rd_ff;
               rsp.offset          = rd_ff;
            end
         end
         ACT_CONSUME: begin
            rd_in = rd_ff + req.byte_count;
         end
         default: begin
            rsp = '{granted: 1'b1, offset: '0, bytes_available: '0};
         end
      endcase
   end

   // offset state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         end_ff <= '0;
      end else if (fire) begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         end_ff <= end_in;
      end
   end

endmodule

>>> rtl/contiguous_reserve_ring_buffer_top.sv
// a request accepted into the request register moves on to the response register once that has room
// throughput: one request per cycle, limited only by the response side stalling
// the offset update sits between the request register and the response register
// reset (synchronous, active high) clears the write, read and end offsets to 0
// and empties both registers; no request is lost or repeated across a stall
// depends on crrb_pkg and crrb_core
module contiguous_reserve_ring_buffer_top
   import crrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_req_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    req_take;
   logic    rsp_take;

   // move the held request into the response register when it has room
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_vld_ff && !rsp_stall;

   assign in_vld_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? 1'b1 : (rsp_take ? 1'b0 : out_vld_ff);

   crrb_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   // request and response valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= req_data;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_rsp_ff;

endmodule

>>> rtl/crrb_checker.sv
// port-level checks for the ring pointer engine, bound to the top level
// depends on crrb_pkg and contiguous_reserve_ring_buffer_top
module crrb_checker
   import crrb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // the request side only stalls behind a full, stalled response register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

   // a refused reserve reports no offset and no span
   a_refuse_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |-> rsp_data.offset == '0 &&
      rsp_data.bytes_available == '0)
      else $error("refused reserve carries data");

   // reset leaves nothing pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("transaction pending after reset");

endmodule

bind contiguous_reserve_ring_buffer_top crrb_checker u_crrb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
